@@ design/zwpt_pkg.sv @@
// Package for the zone write pointer tracker.
// Sizes, operation and status codes, sequencer states.
// No dependencies.
`default_nettype none
package zwpt_pkg;
  localparam int ZONE_SLOTS = 65536;
  localparam int MAX_SPAN  = 16;
  localparam int ZONE_AW   = $clog2(ZONE_SLOTS);
  localparam int CTR_W     = 33;
  localparam int OFF_W     = 48;
  localparam int CNT_W     = 17;
  localparam int ROW_W     = 2 * CTR_W;
  localparam int DIV_STEPS = OFF_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);
  localparam logic [CTR_W-1:0] ZB_MAX = 33'h1_0000_0000;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_ENUM_RS = 3'd2;
  localparam logic [2:0] OP_ENUM_NX = 3'd3;
  localparam logic [2:0] OP_CLEAN   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic CFG_ZONE_BYTES = 1'b0;
  localparam logic CFG_ZONES      = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_CHECK, S_DIV, S_SPAN, S_RD, S_UPD, S_ENRD, S_ENOUT
  } state_t;
endpackage
`default_nettype wire

@@ design/zwpt_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module zwpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/zone_write_pointer_tracker.sv @@
// Zone write pointer tracker: per-zone write pointer and dead-byte table.
// Depends on zwpt_pkg and zwpt_ram.
//
// channel   signals                                          handshake
// command   start, operation, range_offset, range_length,    start & !busy
//           zone_select
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid & cfg_ready
// result    result_valid, zone_index, seg_offset, seg_length, one-cycle strobe
//           write_pointer, dead_bytes, found, status, last
//
// Allocate/release: size check (S_MUL, S_CHECK), the bit-serial divider (S_DIV),
// a span check (S_SPAN), then a table read-modify-write (S_RD, S_UPD) per zone.
// Enumerate next: read (S_ENRD), then result (S_ENOUT). Clean, other codes: in S_IDLE.
// After reset a clearing pass writes all 65536 table rows, one per cycle, with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module zone_write_pointer_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [47:0] range_offset,
  input  wire logic [47:0] range_length,
  input  wire logic [15:0] zone_select,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [32:0] cfg_data,
  output logic             result_valid,
  output logic [15:0]      zone_index,
  output logic [47:0]      seg_offset,
  output logic [32:0]      seg_length,
  output logic [32:0]      write_pointer,
  output logic [32:0]      dead_bytes,
  output logic             found,
  output logic [1:0]       status,
  output logic             last
);
  zwpt_pkg::state_t state, state_next;

  logic [zwpt_pkg::CTR_W-1:0]   zone_bytes;
  logic [zwpt_pkg::CNT_W-1:0]   zones_in_use;
  logic [zwpt_pkg::CTR_W-1:0]   zb;
  logic [zwpt_pkg::CNT_W-1:0]   nz;
  logic [zwpt_pkg::CTR_W-1:0]   zb_eff;
  logic [zwpt_pkg::CNT_W-1:0]   nz_eff;
  logic [2:0]                   op;
  logic [zwpt_pkg::OFF_W-1:0]   off;
  logic [zwpt_pkg::OFF_W-1:0]   len;
  logic [zwpt_pkg::OFF_W:0]     end_sum;
  logic [zwpt_pkg::OFF_W:0]     dev;
  logic [zwpt_pkg::OFF_W-1:0]   quo;
  logic [zwpt_pkg::CTR_W-1:0]   rem;
  logic [zwpt_pkg::DIV_CW-1:0]  div_cnt;
  logic [zwpt_pkg::ZONE_AW-1:0] zone;
  logic [zwpt_pkg::CTR_W-1:0]   piece;
  logic [zwpt_pkg::ZONE_AW-1:0] cursor;
  logic                         started;
  logic [zwpt_pkg::OFF_W-1:0]   prod;
  logic [zwpt_pkg::ZONE_AW-1:0] clr_cnt;

  logic                         we;
  logic [zwpt_pkg::ZONE_AW-1:0] waddr, raddr;
  logic [zwpt_pkg::ROW_W-1:0]   wdata, rdata;

  logic [zwpt_pkg::CTR_W:0]     trial;
  logic                         trial_ge;
  logic [zwpt_pkg::OFF_W:0]     span_sum, span_lim;
  logic [zwpt_pkg::CTR_W-1:0]   room, piece_c;
  logic [zwpt_pkg::CTR_W-1:0]   ctr_old, ctr_new, wp_new, db_new, wpc;
  logic [zwpt_pkg::CTR_W:0]     ctr_sum;
  logic                         sat;
  logic [zwpt_pkg::OFF_W-1:0]   len_rest;
  logic                         accept, enum_end;

  logic                         emit;
  logic [15:0]                  e_zone;
  logic [47:0]                  e_off;
  logic [32:0]                  e_len, e_wp, e_db;
  logic                         e_found, e_last;
  logic [1:0]                   e_status;

  assign cfg_ready = 1'b1;
  assign busy      = (state != zwpt_pkg::S_IDLE);
  assign accept    = start && !busy;

  assign zb_eff = (zone_bytes == '0) ? zwpt_pkg::CTR_W'(1) :
                  (zone_bytes > zwpt_pkg::ZB_MAX) ? zwpt_pkg::ZB_MAX : zone_bytes;
  assign nz_eff = (zones_in_use == '0) ? zwpt_pkg::CNT_W'(1) :
                  (zones_in_use > zwpt_pkg::CNT_W'(zwpt_pkg::ZONE_SLOTS)) ?
                  zwpt_pkg::CNT_W'(zwpt_pkg::ZONE_SLOTS) : zones_in_use;

  assign trial    = {rem, quo[zwpt_pkg::OFF_W-1]};
  assign trial_ge = trial >= {1'b0, zb};
  assign span_sum = {16'b0, rem} + {1'b0, len};
  assign span_lim = {16'b0, zb} * 49'(zwpt_pkg::MAX_SPAN);
  assign room     = zb - rem;
  assign piece_c  = (len < {15'b0, room}) ? len[zwpt_pkg::CTR_W-1:0] : room;
  assign ctr_old  = (op == zwpt_pkg::OP_ALLOC) ? rdata[zwpt_pkg::CTR_W-1:0] :
                    rdata[zwpt_pkg::ROW_W-1:zwpt_pkg::CTR_W];
  assign ctr_sum  = {1'b0, ctr_old} + {1'b0, piece};
  assign sat      = ctr_sum > {1'b0, zb};
  assign ctr_new  = sat ? zb : ctr_sum[zwpt_pkg::CTR_W-1:0];
  assign wp_new   = (op == zwpt_pkg::OP_ALLOC) ? ctr_new : rdata[zwpt_pkg::CTR_W-1:0];
  assign db_new   = (op == zwpt_pkg::OP_ALLOC) ? rdata[zwpt_pkg::ROW_W-1:zwpt_pkg::CTR_W] :
                    ctr_new;
  assign len_rest = len - {15'b0, piece};
  assign wpc      = (rdata[zwpt_pkg::CTR_W-1:0] > zb) ? zb : rdata[zwpt_pkg::CTR_W-1:0];
  assign enum_end = ({1'b0, cursor} + zwpt_pkg::CNT_W'(1)) >= nz_eff;

  zwpt_ram #(
    .WIDTH(zwpt_pkg::ROW_W),
    .DEPTH(zwpt_pkg::ZONE_SLOTS)
  ) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zwpt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we       = 1'b0;
    waddr    = zone;
    wdata    = '0;
    raddr    = zone;
    emit     = 1'b0;
    e_zone   = '0;
    e_off    = '0;
    e_len    = '0;
    e_wp     = '0;
    e_db     = '0;
    e_found  = 1'b0;
    e_status = zwpt_pkg::ST_OK;
    e_last   = 1'b1;
    case (state)
      zwpt_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        if (clr_cnt == '1) begin
          state_next = zwpt_pkg::S_IDLE;
        end
      end
      zwpt_pkg::S_IDLE: begin
        if (accept) begin
          case (operation)
            zwpt_pkg::OP_ALLOC, zwpt_pkg::OP_RELEASE: begin
              if (range_length != '0) begin
                state_next = zwpt_pkg::S_MUL;
              end
            end
            zwpt_pkg::OP_ENUM_NX: begin
              if (started && enum_end) begin
                emit = 1'b1;
              end else begin
                state_next = zwpt_pkg::S_ENRD;
              end
            end
            zwpt_pkg::OP_CLEAN: begin
              emit = 1'b1;
              if ({1'b0, zone_select} >= nz_eff) begin
                e_status = zwpt_pkg::ST_REJECTED;
              end else begin
                we     = 1'b1;
                waddr  = zone_select;
                e_zone = zone_select;
              end
            end
            default: ;
          endcase
        end
      end
      zwpt_pkg::S_MUL: state_next = zwpt_pkg::S_CHECK;
      zwpt_pkg::S_CHECK: begin
        if (end_sum > dev) begin
          emit       = 1'b1;
          e_status   = zwpt_pkg::ST_REJECTED;
          state_next = zwpt_pkg::S_IDLE;
        end else begin
          state_next = zwpt_pkg::S_DIV;
        end
      end
      zwpt_pkg::S_DIV: begin
        if (div_cnt == '0) begin
          state_next = zwpt_pkg::S_SPAN;
        end
      end
      zwpt_pkg::S_SPAN: begin
        if (span_sum > span_lim) begin
          emit       = 1'b1;
          e_status   = zwpt_pkg::ST_REJECTED;
          state_next = zwpt_pkg::S_IDLE;
        end else begin
          state_next = zwpt_pkg::S_RD;
        end
      end
      zwpt_pkg::S_RD: state_next = zwpt_pkg::S_UPD;
      zwpt_pkg::S_UPD: begin
        we       = 1'b1;
        wdata    = {db_new, wp_new};
        emit     = 1'b1;
        e_zone   = 16'(zone);
        e_off    = off;
        e_len    = piece;
        e_wp     = wp_new;
        e_db     = db_new;
        e_status = sat ? zwpt_pkg::ST_SAT : zwpt_pkg::ST_OK;
        e_last   = (len_rest == '0);
        state_next = e_last ? zwpt_pkg::S_IDLE : zwpt_pkg::S_RD;
      end
      zwpt_pkg::S_ENRD: begin
        raddr      = cursor;
        state_next = zwpt_pkg::S_ENOUT;
      end
      zwpt_pkg::S_ENOUT: begin
        emit       = 1'b1;
        e_zone     = 16'(cursor);
        e_off      = prod + {15'b0, wpc};
        e_len      = zb - wpc;
        e_wp       = rdata[zwpt_pkg::CTR_W-1:0];
        e_db       = rdata[zwpt_pkg::ROW_W-1:zwpt_pkg::CTR_W];
        e_found    = 1'b1;
        state_next = zwpt_pkg::S_IDLE;
      end
      default: state_next = zwpt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_bytes   <= 33'd268435456;
      zones_in_use <= 17'd65536;
      started      <= 1'b0;
      cursor       <= '0;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == zwpt_pkg::CFG_ZONE_BYTES) begin
          zone_bytes <= cfg_data;
        end else begin
          zones_in_use <= cfg_data[zwpt_pkg::CNT_W-1:0];
        end
      end
      if (state == zwpt_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept && operation == zwpt_pkg::OP_ENUM_RS) begin
        started <= 1'b0;
        cursor  <= '0;
      end
      if (accept && operation == zwpt_pkg::OP_ENUM_NX) begin
        if (!started) begin
          started <= 1'b1;
          cursor  <= '0;
        end else if (!enum_end) begin
          cursor <= cursor + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      zone_index    <= e_zone;
      seg_offset    <= e_off;
      seg_length    <= e_len;
      write_pointer <= e_wp;
      dead_bytes    <= e_db;
      found         <= e_found;
      status        <= e_status;
      last          <= e_last;
    end
    case (state)
      zwpt_pkg::S_IDLE: begin
        op  <= operation;
        off <= range_offset;
        len <= range_length;
        zb  <= zb_eff;
        nz  <= nz_eff;
      end
      zwpt_pkg::S_MUL: begin
        dev     <= {32'b0, nz} * {16'b0, zb};
        end_sum <= {1'b0, off} + {1'b0, len};
        quo     <= off;
        rem     <= '0;
        div_cnt <= zwpt_pkg::DIV_CW'(zwpt_pkg::DIV_STEPS - 1);
      end
      zwpt_pkg::S_DIV: begin
        quo     <= {quo[zwpt_pkg::OFF_W-2:0], trial_ge};
        rem     <= trial_ge ? 33'(trial - {1'b0, zb}) : trial[zwpt_pkg::CTR_W-1:0];
        div_cnt <= div_cnt - 1'b1;
      end
      zwpt_pkg::S_SPAN: zone <= quo[zwpt_pkg::ZONE_AW-1:0];
      zwpt_pkg::S_RD: piece <= piece_c;
      zwpt_pkg::S_UPD: begin
        off  <= off + {15'b0, piece};
        len  <= len_rest;
        rem  <= '0;
        zone <= zone + 1'b1;
      end
      zwpt_pkg::S_ENRD: prod <= {32'b0, cursor} * {15'b0, zb};
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ bench/zone_write_pointer_tracker_tb.sv @@
// Testbench for zone_write_pointer_tracker: directed and random commands under
// several zone geometries, checked against a scoreboard that tracks the zone table.
// Depends on zwpt_pkg and the tracker RTL.
`timescale 1ns / 100ps
module zone_write_pointer_tracker_tb;

  typedef struct packed {
    bit [15:0] zone;
    bit [47:0] seg_off;
    bit [32:0] seg_len;
    bit [32:0] wp;
    bit [32:0] dead;
    bit        fnd;
    bit [1:0]  st;
    bit        lst;
  } zone_result_t;

  class zone_ledger;
    bit [32:0]   wp_tab[int];
    bit [32:0]   dead_tab[int];
    int unsigned cursor;
    bit          started;
    bit [32:0]   zone_size_reg;
    bit [16:0]   zone_count_reg;
    zone_result_t pending[$];
    int          mismatches;
    int          checked;

    function new();
      zone_size_reg  = 33'd268435456;
      zone_count_reg = 17'd65536;
    endfunction

    function void set_reg(bit idx, bit [32:0] data);
      if (idx == zwpt_pkg::CFG_ZONE_BYTES) zone_size_reg = data;
      else zone_count_reg = data[16:0];
    endfunction

    function longint unsigned zsize();
      if (zone_size_reg == 0) return 1;
      if (zone_size_reg > zwpt_pkg::ZB_MAX) return 64'h1_0000_0000;
      return zone_size_reg;
    endfunction

    function longint unsigned zcount();
      if (zone_count_reg == 0) return 1;
      if (zone_count_reg > zwpt_pkg::ZONE_SLOTS) return zwpt_pkg::ZONE_SLOTS;
      return zone_count_reg;
    endfunction

    function void push(longint unsigned zi, longint unsigned so, longint unsigned sl,
                       longint unsigned wp, longint unsigned db, bit fd, bit [1:0] st,
                       bit ls);
      zone_result_t r;
      r.zone = zi[15:0]; r.seg_off = so[47:0]; r.seg_len = sl[32:0];
      r.wp = wp[32:0]; r.dead = db[32:0]; r.fnd = fd; r.st = st; r.lst = ls;
      pending.push_back(r);
    endfunction

    function void note(bit [2:0] op, bit [47:0] off48, bit [47:0] len48, bit [15:0] sel);
      longint unsigned zb, nz, off, len, z, room, piece, nv, wpc;
      bit [1:0] st;
      zb = zsize();
      nz = zcount();
      off = off48;
      len = len48;
      case (op)
        zwpt_pkg::OP_ALLOC, zwpt_pkg::OP_RELEASE: begin
          if (len == 0) return;
          if (off + len > nz * zb ||
              (off + len - 1) / zb - off / zb + 1 > zwpt_pkg::MAX_SPAN) begin
            push(0, 0, 0, 0, 0, 0, zwpt_pkg::ST_REJECTED, 1);
            return;
          end
          while (len > 0) begin
            z = off / zb;
            room = zb - off % zb;
            piece = len < room ? len : room;
            if (!wp_tab.exists(z)) wp_tab[z] = 0;
            if (!dead_tab.exists(z)) dead_tab[z] = 0;
            nv = (op == zwpt_pkg::OP_ALLOC ? wp_tab[z] : dead_tab[z]) + piece;
            st = zwpt_pkg::ST_OK;
            if (nv > zb) begin
              nv = zb;
              st = zwpt_pkg::ST_SAT;
            end
            if (op == zwpt_pkg::OP_ALLOC) wp_tab[z] = nv;
            else dead_tab[z] = nv;
            len -= piece;
            push(z, off, piece, wp_tab[z], dead_tab[z], 0, st, len == 0);
            off += piece;
          end
        end
        zwpt_pkg::OP_ENUM_RS: begin
          started = 0;
          cursor = 0;
        end
        zwpt_pkg::OP_ENUM_NX: begin
          if (!started) begin
            started = 1;
            cursor = 0;
          end else if (cursor + 1 >= nz) begin
            push(0, 0, 0, 0, 0, 0, zwpt_pkg::ST_OK, 1);
            return;
          end else begin
            cursor++;
          end
          nv = wp_tab.exists(cursor) ? wp_tab[cursor] : 0;
          wpc = nv > zb ? zb : nv;
          push(cursor, cursor * zb + wpc, zb - wpc, nv,
               dead_tab.exists(cursor) ? dead_tab[cursor] : 0, 1, zwpt_pkg::ST_OK, 1);
        end
        zwpt_pkg::OP_CLEAN: begin
          if (sel >= nz) begin
            push(0, 0, 0, 0, 0, 0, zwpt_pkg::ST_REJECTED, 1);
            return;
          end
          wp_tab[sel] = 0;
          dead_tab[sel] = 0;
          push(sel, 0, 0, 0, 0, 0, zwpt_pkg::ST_OK, 1);
        end
        default: ;
      endcase
    endfunction

    function void check(zone_result_t got);
      zone_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result zone %h status %0d", $time, got.zone, got.st);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch", $time);
          $display("  exp zone %h off %h len %h wp %h dead %h fnd %b st %0d last %b",
                   exp_r.zone, exp_r.seg_off, exp_r.seg_len, exp_r.wp, exp_r.dead,
                   exp_r.fnd, exp_r.st, exp_r.lst);
          $display("  got zone %h off %h len %h wp %h dead %h fnd %b st %0d last %b",
                   got.zone, got.seg_off, got.seg_len, got.wp, got.dead,
                   got.fnd, got.st, got.lst);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  operation = 0;
  logic [47:0] range_offset = 0;
  logic [47:0] range_length = 0;
  logic [15:0] zone_select = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [32:0] cfg_data = 0;
  logic        result_valid;
  logic [15:0] zone_index;
  logic [47:0] seg_offset;
  logic [32:0] seg_length;
  logic [32:0] write_pointer;
  logic [32:0] dead_bytes;
  logic        found;
  logic [1:0]  status;
  logic        last;

  zone_ledger ledger = new();
  int         accepted;
  bit         quiet;

  zone_write_pointer_tracker dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    zone_result_t r;
    if (!rst && result_valid) begin
      r.zone = zone_index; r.seg_off = seg_offset; r.seg_len = seg_length;
      r.wp = write_pointer; r.dead = dead_bytes; r.fnd = found; r.st = status;
      r.lst = last;
      ledger.check(r);
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(bit [2:0] op, bit [47:0] off, bit [47:0] len, bit [15:0] sel);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    operation = op;
    range_offset = off;
    range_length = len;
    zone_select = sel;
    start = 1;
    do @(posedge clk); while (busy);
    ledger.note(op, off, len, sel);
    accepted++;
    @(negedge clk);
  endtask

  task automatic write_reg(bit idx, bit [32:0] data);
    start = 0;
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    start = 0;
    while (ledger.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic random_item();
    longint unsigned zb, nz, z, off, len;
    int kind;
    zb = ledger.zsize();
    nz = ledger.zcount();
    kind = $urandom_range(0, 99);
    z = $urandom_range(0, nz - 1);
    off = z * zb + rand64() % zb;
    if (kind < 45) begin
      if ($urandom_range(0, 4) == 0) off = z * zb;
      len = rand64() % ($urandom_range(1, 4) * zb) + 1;
      send($urandom_range(0, 1), off, len, 0);
    end else if (kind < 60) send(zwpt_pkg::OP_ENUM_NX, rand64(), rand64(), $urandom);
    else if (kind < 65) send(zwpt_pkg::OP_ENUM_RS, rand64(), rand64(), $urandom);
    else if (kind < 72) send(zwpt_pkg::OP_CLEAN, 0, 0, $urandom_range(0, nz + 1));
    else if (kind < 75) send(zwpt_pkg::OP_CLEAN, rand64(), rand64(), $urandom);
    else if (kind < 85) send($urandom_range(0, 1), rand64(), rand64(), $urandom);
    else if (kind < 90) send($urandom_range(0, 1), rand64(), 0, 0);
    else if (kind < 95) send($urandom_range(5, 7), rand64(), rand64(), $urandom);
    else send($urandom_range(0, 1), off, (17 + $urandom_range(0, 3)) * zb, 0);
  endtask

  task automatic phase(bit [32:0] zb, bit [32:0] nz, int count);
    drain();
    write_reg(zwpt_pkg::CFG_ZONE_BYTES, zb);
    write_reg(zwpt_pkg::CFG_ZONES, nz);
    repeat (count) random_item();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(zwpt_pkg::CFG_ZONE_BYTES, 33'd4096);
    write_reg(zwpt_pkg::CFG_ZONES, 33'd8);
    send(zwpt_pkg::OP_ALLOC, 0, 4096, 0);
    send(zwpt_pkg::OP_ALLOC, 100, 5000, 0);
    send(zwpt_pkg::OP_RELEASE, 0, 8 * 4096, 0);
    send(zwpt_pkg::OP_RELEASE, 0, 1, 0);
    send(zwpt_pkg::OP_ALLOC, 5, 0, 0);
    send(zwpt_pkg::OP_ALLOC, 8 * 4096 - 1, 2, 0);
    send(zwpt_pkg::OP_RELEASE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send(zwpt_pkg::OP_ENUM_RS, 0, 0, 0);
    repeat (10) send(zwpt_pkg::OP_ENUM_NX, 0, 0, 0);
    send(zwpt_pkg::OP_CLEAN, 0, 0, 3);
    send(zwpt_pkg::OP_CLEAN, 0, 0, 8);
    send(zwpt_pkg::OP_CLEAN, 0, 0, 16'hFFFF);
    send(3'd5, 0, 0, 0);
    send(3'd6, 0, 0, 0);
    send(3'd7, 0, 0, 0);
    repeat (10) random_item();

    phase(33'd0, 33'd3, 14);
    phase(33'd1000, 33'd40, 16);
    phase(33'h1_FFFF_FFFF, 33'd0, 12);
    phase(33'h1_0000_0000, 33'h0_0001_0000, 14);
    phase(33'd268435456, 33'h1_FFFF_FFFF, 12);
    quiet = 1;
    phase(33'd777, 33'd20, 16);

    drain();
    repeat (100) @(posedge clk);
    $display("Accepted %0d commands over 7 zone geometries; %0d results checked, %0d bad.",
             accepted, ledger.checked, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
